/* design/slrbm_pkg.sv */
// shared types, codes and constants of the serial loaded bank mapper
package slrbm_pkg;

  // translated offset width inside the mapper, and the output field width
  localparam int ROM_OFFSET_BITS  = 18;
  localparam int OUT_OFFSET_BITS  = 18;
  localparam int OFFSET_CALC_BITS = 20;
  localparam logic [OFFSET_CALC_BITS-1:0] OFFSET_MASK =
    OFFSET_CALC_BITS'((64'd1 << ROM_OFFSET_BITS) - 64'd1);

  // transaction kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_PRG   = 2'd1;
  localparam logic [1:0] KIND_CHR   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_USES_RAM   = 1'b1;

  // serial load targets, from address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // prg modes, control bits 3:2
  localparam logic [1:0] PRG_MODE_32K_A     = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_B     = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] SHIFT_MARKER   = 5'h10;
  localparam logic [4:0] CONTROL_RESET  = 5'h0c;
  localparam logic [4:0] CONTROL_MODE3  = 5'h0c;
  localparam logic [4:0] BANK_COUNT_RST = 5'd2;

  // mapper register file
  typedef struct packed {
    logic [4:0] serial_shift;
    logic [4:0] control;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg;
  } map_state_t;

endpackage

/* design/slrbm_loader.sv */
// serial shift register and bank register file of the mapper
module slrbm_loader (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [1:0]              kind,
  input  logic [15:0]             address,
  input  logic [7:0]              write_data,
  output slrbm_pkg::map_state_t   state,
  output logic [4:0]              control_next
);

  slrbm_pkg::map_state_t regs;
  slrbm_pkg::map_state_t regs_next;
  logic [4:0]            shifted;

  assign shifted = {write_data[0], regs.serial_shift[4:1]};

  always_comb begin
    regs_next = regs;
    if (step && kind == slrbm_pkg::KIND_WRITE) begin
      if (write_data[7]) begin
        regs_next.control      = regs.control | slrbm_pkg::CONTROL_MODE3;
        regs_next.serial_shift = slrbm_pkg::SHIFT_MARKER;
      end else if (regs.serial_shift[0]) begin
        regs_next.serial_shift = slrbm_pkg::SHIFT_MARKER;
        unique case (address[14:13])
          slrbm_pkg::SEL_CONTROL: regs_next.control = shifted;
          slrbm_pkg::SEL_CHR_LO:  regs_next.chr_lo  = shifted;
          slrbm_pkg::SEL_CHR_HI:  regs_next.chr_hi  = shifted;
          default:                regs_next.prg     = shifted;
        endcase
      end else begin
        regs_next.serial_shift = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.serial_shift <= slrbm_pkg::SHIFT_MARKER;
      regs.control      <= slrbm_pkg::CONTROL_RESET;
      regs.chr_lo       <= '0;
      regs.chr_hi       <= '0;
      regs.prg          <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  assign state        = regs;
  assign control_next = regs_next.control;

endmodule

/* design/slrbm_translate.sv */
// prg and chr address translation against the current bank registers
module slrbm_translate (
  input  slrbm_pkg::map_state_t                 state,
  input  logic [4:0]                            prg_bank_count,
  input  logic                                  chr_uses_ram,
  input  logic [1:0]                            kind,
  input  logic [15:0]                           address,
  output logic [slrbm_pkg::OUT_OFFSET_BITS-1:0] rom_offset,
  output logic                                  targets_chr_ram
);

  localparam int CW = slrbm_pkg::OFFSET_CALC_BITS;

  logic [4:0]    count;
  logic [4:0]    last_bank;
  logic [4:0]    prg_lo_bank;
  logic [4:0]    prg_hi_bank;
  logic [4:0]    prg_bank;
  logic [18:0]   prg_offset;
  logic [4:0]    chr_lo_bank;
  logic [4:0]    chr_hi_bank;
  logic [4:0]    chr_bank;
  logic [16:0]   chr_offset;
  logic [CW-1:0] offset;
  logic [CW-1:0] offset_masked;

  // a bank count of zero acts as one bank
  assign count     = (prg_bank_count == 5'd0) ? 5'd1 : prg_bank_count;
  assign last_bank = count - 5'd1;

  always_comb begin
    unique case (state.control[3:2])
      slrbm_pkg::PRG_MODE_32K_A, slrbm_pkg::PRG_MODE_32K_B: begin
        prg_lo_bank = {1'b0, state.prg[3:1], 1'b0};
        prg_hi_bank = {1'b0, state.prg[3:1], 1'b1};
      end
      slrbm_pkg::PRG_MODE_FIX_FIRST: begin
        prg_lo_bank = 5'd0;
        prg_hi_bank = {1'b0, state.prg[3:0]};
      end
      default: begin
        prg_lo_bank = {1'b0, state.prg[3:0]};
        prg_hi_bank = last_bank;
      end
    endcase
  end

  assign prg_bank   = (address < 16'hc000) ? prg_lo_bank : prg_hi_bank;
  assign prg_offset = {prg_bank, address[13:0]};

  // 4 KB banking when control bit 4 is set, else one 8 KB pair
  assign chr_lo_bank = state.control[4] ? state.chr_lo : {state.chr_lo[4:1], 1'b0};
  assign chr_hi_bank = state.control[4] ? state.chr_hi : {state.chr_lo[4:1], 1'b1};
  assign chr_bank    = (address < 16'h1000) ? chr_lo_bank : chr_hi_bank;
  assign chr_offset  = {chr_bank, address[11:0]};

  always_comb begin
    offset          = '0;
    targets_chr_ram = 1'b0;
    unique case (kind)
      slrbm_pkg::KIND_PRG: offset = {{(CW-19){1'b0}}, prg_offset};
      slrbm_pkg::KIND_CHR: begin
        targets_chr_ram = chr_uses_ram;
        if (chr_uses_ram) begin
          offset = {{(CW-13){1'b0}}, address[12:0]};
        end else begin
          offset = {{(CW-17){1'b0}}, chr_offset};
        end
      end
      default: offset = '0;
    endcase
  end

  assign offset_masked = offset & slrbm_pkg::OFFSET_MASK;
  assign rom_offset    = offset_masked[slrbm_pkg::OUT_OFFSET_BITS-1:0];

endmodule

/* design/serial_loaded_rom_bank_mapper_core.sv */
// top level of the serial loaded cartridge bank mapper
//
// One transaction per cycle sustained while out_stall stays low. A
// transaction is taken into the input register, passes the translate and
// register-load logic and lands in the result register, which offers its
// result. A result waiting under stall keeps the input register filled,
// and only then does in_stall rise. Kind 0 transactions clock the serial
// shift register and the bank registers as they move into the result
// register, so every later transaction sees the updated banks. Every
// transaction gives exactly one result: writes and the unused kind report
// offset 0, and mirroring is control bits 1:0 after the transaction.
// Configuration (bank count, chr ram) is to be written only while idle by
// the user; the block itself does not enforce this.
module serial_loaded_rom_bank_mapper_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write_en,
  input  logic                                  cfg_index,
  input  logic [4:0]                            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            kind,
  input  logic [15:0]                           address,
  input  logic [7:0]                            write_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [slrbm_pkg::OUT_OFFSET_BITS-1:0] rom_offset,
  output logic [1:0]                            mirroring,
  output logic                                  targets_chr_ram
);

  // configuration registers
  logic [4:0] prg_bank_count;
  logic       chr_uses_ram;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [15:0] s1_address;
  logic [7:0]  s1_data;

  logic in_take;
  logic advance;

  slrbm_pkg::map_state_t                 state;
  logic [4:0]                            control_next;
  logic [slrbm_pkg::OUT_OFFSET_BITS-1:0] offset_calc;
  logic                                  to_ram_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= slrbm_pkg::BANK_COUNT_RST;
      chr_uses_ram   <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        slrbm_pkg::CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
        default:                       chr_uses_ram   <= cfg_data[0];
      endcase
    end
  end

  // input register moves on when the result register is free or being taken
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind    <= kind;
      s1_address <= address;
      s1_data    <= write_data;
    end
  end

  // bank registers update as the transaction leaves the input register
  slrbm_loader u_loader (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .kind         (s1_kind),
    .address      (s1_address),
    .write_data   (s1_data),
    .state        (state),
    .control_next (control_next)
  );

  // translation sees the banks from before this transaction
  slrbm_translate u_translate (
    .state           (state),
    .prg_bank_count  (prg_bank_count),
    .chr_uses_ram    (chr_uses_ram),
    .kind            (s1_kind),
    .address         (s1_address),
    .rom_offset      (offset_calc),
    .targets_chr_ram (to_ram_calc)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rom_offset      <= offset_calc;
      mirroring       <= control_next[1:0];
      targets_chr_ram <= to_ram_calc;
    end
  end

  // a reset write forces the fixed-last prg mode
  a_reset_write_mode3: assert property (@(posedge clk) disable iff (rst)
    advance && s1_kind == slrbm_pkg::KIND_WRITE && s1_data[7]
      |=> state.control[3:2] == slrbm_pkg::PRG_MODE_FIX_LAST)
    else $error("reset write did not force prg mode 3");

  // only chr transactions may point at chr ram
  a_ram_only_chr: assert property (@(posedge clk) disable iff (rst)
    advance && s1_kind != slrbm_pkg::KIND_CHR |=> !targets_chr_ram)
    else $error("non-chr transaction flagged as chr ram");

  // the shift register always carries its marker bit somewhere
  a_marker_present: assert property (@(posedge clk) disable iff (rst)
    state.serial_shift != 5'd0)
    else $error("serial shift register lost its marker");

  // the input register stalls only while a result waits under stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
